// ----- sv/tpfs_pkg.sv -----
// Shared constants and types for the tachometer period fan speed regulator.
// No dependencies; compiled before the interfaces and the top level.

package tpfs_pkg;

  localparam int CAPTURE_WIDTH_DEF = 16;
  localparam int SPEED_WIDTH_DEF   = 22;
  localparam int DUTY_WIDTH        = 16;

  localparam int SPEED_CONSTANT_RESET = 3750000;
  localparam logic [DUTY_WIDTH-1:0] DUTY_LIMIT_RESET = 16'hFFFF;

  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;

  // Register select, taken from paddr[2]
  localparam logic REG_SPEED_CONSTANT = 1'b0;
  localparam logic REG_DUTY_LIMIT     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_UPDATE
  } tpfs_state_e;

endpackage

// ----- sv/tpfs_in_if.sv -----
// Input channel of the regulator: valid/ready handshake with one capture item.
// Depends on tpfs_pkg for default widths.

interface tpfs_in_if
  import tpfs_pkg::*;
#(
  parameter int CAPTURE_WIDTH = CAPTURE_WIDTH_DEF,
  parameter int SPEED_WIDTH   = SPEED_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [CAPTURE_WIDTH-1:0] capture_time;
  logic [SPEED_WIDTH-1:0]   target_speed;

  modport source (output valid, output capture_time, output target_speed, input ready);
  modport sink   (input valid, input capture_time, input target_speed, output ready);
endinterface

// ----- sv/tpfs_out_if.sv -----
// Result channel of the regulator: valid/ready handshake with one result item.
// Depends on tpfs_pkg for default widths.

interface tpfs_out_if
  import tpfs_pkg::*;
#(
  parameter int CAPTURE_WIDTH = CAPTURE_WIDTH_DEF,
  parameter int SPEED_WIDTH   = SPEED_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [SPEED_WIDTH-1:0]   measured_speed;
  logic [CAPTURE_WIDTH:0]   edge_period;
  logic [DUTY_WIDTH-1:0]    duty_value;
  logic                     duty_changed;

  modport source (output valid, output measured_speed, output edge_period,
                  output duty_value, output duty_changed, input ready);
  modport sink   (input valid, input measured_speed, input edge_period,
                  input duty_value, input duty_changed, output ready);
endinterface

// ----- sv/tach_period_fan_speed_regulator.sv -----
// Tachometer period fan speed regulator. Each accepted item goes through taking
// the capture and forming the period, the radix-2 restoring divider that yields
// one quotient bit per cycle, and stepping the duty and loading the result
// register. Input ready is low from acceptance until the update step is done; a
// result still waiting in the output register delays the update step until it is
// taken. Configuration over APB: speed_constant at byte address 0, duty_limit at
// byte address 4.
// Depends on tpfs_pkg, tpfs_in_if and tpfs_out_if.

module tach_period_fan_speed_regulator
  import tpfs_pkg::*;
#(
  parameter int CAPTURE_WIDTH = CAPTURE_WIDTH_DEF,
  parameter int SPEED_WIDTH   = SPEED_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tpfs_in_if.sink                   in_i,
  tpfs_out_if.source                out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  localparam int CW    = CAPTURE_WIDTH;
  localparam int SW    = SPEED_WIDTH;
  localparam int CNT_W = $clog2(SW);

  // Configuration
  logic [SW-1:0]         speed_const_q;
  logic [DUTY_WIDTH-1:0] duty_limit_q;
  logic                  cfg_wr;

  // Control and state
  tpfs_state_e           state_q, state_d;
  logic [CW-1:0]         last_cap_q;
  logic [DUTY_WIDTH-1:0] duty_q, duty_d;
  logic                  changed_d;

  // Divider datapath
  logic [CW:0]           period_q;
  logic [SW-1:0]         target_q;
  logic [SW-1:0]         quo_q;
  logic [CW:0]           rem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [CW+1:0]         rem_shift;
  logic [CW+1:0]         rem_diff;
  logic                  quo_bit;
  logic [CW-1:0]         cap_diff;
  logic [CW:0]           period_new;

  // Result register
  logic                  out_valid_q;
  logic [SW-1:0]         out_speed_q;
  logic [CW:0]           out_period_q;
  logic [DUTY_WIDTH-1:0] out_duty_q;
  logic                  out_changed_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  load_out;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SPEED_CONSTANT: prdata[SW-1:0] = speed_const_q;
      REG_DUTY_LIMIT:     prdata[DUTY_WIDTH-1:0] = duty_limit_q;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_const_q <= SW'(SPEED_CONSTANT_RESET);
      duty_limit_q  <= DUTY_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SPEED_CONSTANT: speed_const_q <= pwdata[SW-1:0];
        REG_DUTY_LIMIT:     duty_limit_q  <= pwdata[DUTY_WIDTH-1:0];
        default:            ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;

  // Equal captures mean a full timer span
  assign cap_diff   = in_i.capture_time - last_cap_q;
  assign period_new = (cap_diff == '0) ? {1'b1, {CW{1'b0}}} : {1'b0, cap_diff};

  // One restoring division step: bring down the next dividend bit
  assign rem_shift = {rem_q, quo_q[SW-1]};
  assign rem_diff  = rem_shift - {1'b0, period_q};
  assign quo_bit   = (rem_shift >= {1'b0, period_q});

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_DIVIDE;
      ST_DIVIDE: if (cnt_q == '0) state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Bang-bang step with saturation at zero and at the limit
  always_comb begin
    duty_d    = duty_q;
    changed_d = 1'b0;
    if (quo_q < target_q) begin
      if (duty_q < duty_limit_q) begin
        duty_d    = duty_q + 1'b1;
        changed_d = 1'b1;
      end
    end else if (quo_q > target_q) begin
      if (duty_q != '0) begin
        duty_d    = duty_q - 1'b1;
        changed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_cap_q  <= '0;
      duty_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        last_cap_q <= in_i.capture_time;
        cnt_q      <= CNT_W'(SW - 1);
      end else if (state_q == ST_DIVIDE) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (load_out) begin
        duty_q      <= duty_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      period_q <= period_new;
      target_q <= in_i.target_speed;
      quo_q    <= speed_const_q;
      rem_q    <= '0;
    end else if (state_q == ST_DIVIDE) begin
      rem_q <= quo_bit ? rem_diff[CW:0] : rem_shift[CW:0];
      quo_q <= {quo_q[SW-2:0], quo_bit};
    end
    if (load_out) begin
      out_speed_q   <= quo_q;
      out_period_q  <= period_q;
      out_duty_q    <= duty_d;
      out_changed_q <= changed_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.measured_speed = out_speed_q;
  assign out_o.edge_period    = out_period_q;
  assign out_o.duty_value     = out_duty_q;
  assign out_o.duty_changed   = out_changed_q;

  // Duty moves by at most one per update
  a_duty_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_q != $past(duty_q)) |->
      (duty_q == $past(duty_q) + 1'b1 || duty_q == $past(duty_q) - 1'b1))
    else $error("duty moved by more than one");

  // A new result only ever comes from the update step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_UPDATE)
    else $error("result loaded outside the update step");

  // The divider runs exactly to its last quotient bit
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && cnt_q == '0) |=> state_q == ST_UPDATE)
    else $error("divider did not finish on its last step");

  // The period handed out is never zero
  a_period_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_period_q != '0)
    else $error("zero edge period on the result");

endmodule
